[rtl/lav_pkg.sv]
// Shared types, constants and arithmetic helpers of the look-at view matrix block.
`default_nettype none
package lav_pkg;

  // Widths of the normalize unit.
  localparam int NW  = 50;   // signed component width at the normalize input
  localparam int MW  = 30;   // component magnitude after range alignment
  localparam int SDW = 192;  // side payload carried through the normalize unit
  localparam int QW  = 17;   // quotient bits of a unit component
  localparam int RW  = 48;   // division remainder width

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Per-item data that travels down the square-root and divide stages.
  typedef struct packed {
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][MW-1:0]     m;
    logic [63:0]            s;
    logic [63:0]            res;
    logic [30:0]            len;
    logic [2:0][RW-1:0]     rem;
    logic [2:0][QW-1:0]     q;
    logic [SDW-1:0]         side;
  } nrm_t;

  // Per-item data of the cross product and translation stages.
  typedef struct packed {
    logic [2:0][17:0]  rt;
    logic [2:0][17:0]  bk;
    logic [2:0][17:0]  cu;
    logic [2:0][31:0]  eye;
    logic [2:0][35:0]  pa;
    logic [2:0][35:0]  pb;
    logic [2:0][49:0]  pr;
    logic [2:0][49:0]  pk;
    logic [2:0][49:0]  pu;
    logic [2:0][36:0]  yd;
    logic [2:0][36:0]  ymag;
    logic [2:0]        yneg;
    logic [51:0]       dr;
    logic [51:0]       db;
    logic [51:0]       du;
    logic [51:0]       drm;
    logic [51:0]       dbm;
    logic [51:0]       dum;
    logic              drn;
    logic              dbn;
    logic              dun;
    logic [31:0]       shx;
    logic [31:0]       shy;
    logic [31:0]       shz;
  } tl_t;

  function automatic logic signed [49:0] mul_32x18(logic signed [31:0] a,
                                                   logic signed [17:0] b);
    return a * b;
  endfunction

  function automatic logic signed [35:0] mul_18x18(logic signed [17:0] a,
                                                   logic signed [17:0] b);
    return a * b;
  endfunction

  function automatic logic [59:0] mul_30x30(logic [29:0] a, logic [29:0] b);
    return a * b;
  endfunction

  // Round a Q20.32 magnitude to Q16.16, negate the signed value and saturate.
  function automatic logic [31:0] neg_sat(logic [51:0] mag, logic neg);
    logic [51:0] r;
    logic [31:0] t;
    r = (mag + 52'd32768) >> 16;
    t = r[31:0];
    if (neg) begin
      if (r > 52'h7FFFFFFF) begin
        return 32'h7FFFFFFF;
      end
      return t;
    end
    if (r > 52'h80000000) begin
      return 32'h80000000;
    end
    return ~t + 32'd1;
  endfunction

  // Round a Q5.32 magnitude to Q2.16, clamp to one and apply the sign.
  function automatic logic [17:0] unit_rnd(logic [36:0] mag, logic neg);
    logic [36:0] r;
    logic [17:0] u;
    r = (mag + 37'd32768) >> 16;
    if (r > 37'd65536) begin
      r = 37'd65536;
    end
    u = r[17:0];
    return neg ? (~u + 18'd1) : u;
  endfunction

endpackage
`default_nettype wire

[rtl/lav_norm.sv]
// Pipelined vector normalize unit: range alignment, square root and divide.
`default_nettype none
module lav_norm (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_v,
  input  logic [2:0][lav_pkg::NW-1:0]           in_c,
  input  logic [lav_pkg::SDW-1:0]               in_side,
  output logic                                  out_v,
  output logic [2:0][17:0]                      out_n,
  output logic [lav_pkg::SDW-1:0]               out_side
);

  localparam int NSQ = 32;
  localparam int NDV = 17;
  localparam int NP  = NSQ + NDV + 1;

  // Stage A: magnitudes and the largest one.
  logic [2:0][lav_pkg::NW-1:0] amag;
  logic [lav_pkg::NW-1:0]      atop;
  logic                        a_v_r;
  logic [2:0][lav_pkg::NW-1:0] a_mag_r;
  logic [2:0]                  a_neg_r;
  logic [lav_pkg::NW-1:0]      a_top_r;
  logic [lav_pkg::SDW-1:0]     a_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = in_c[i][lav_pkg::NW-1] ? (~in_c[i] + 50'd1) : in_c[i];
    end
    atop = amag[0];
    if (amag[1] > atop) begin
      atop = amag[1];
    end
    if (amag[2] > atop) begin
      atop = amag[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag_r  <= amag;
      a_neg_r  <= {in_c[2][lav_pkg::NW-1], in_c[1][lav_pkg::NW-1], in_c[0][lav_pkg::NW-1]};
      a_top_r  <= atop;
      a_side_r <= in_side;
    end
  end

  // Stage B: position of the leading one of the largest magnitude.
  logic [5:0]                  bpos;
  logic                        b_v_r;
  logic [2:0][lav_pkg::NW-1:0] b_mag_r;
  logic [2:0]                  b_neg_r;
  logic                        b_zero_r;
  logic [5:0]                  b_pos_r;
  logic [lav_pkg::SDW-1:0]     b_side_r;

  always_comb begin
    bpos = 6'd0;
    for (int i = 0; i < lav_pkg::NW; i++) begin
      if (a_top_r[i]) begin
        bpos = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_mag_r  <= a_mag_r;
      b_neg_r  <= a_neg_r;
      b_zero_r <= (a_top_r == '0);
      b_pos_r  <= bpos;
      b_side_r <= a_side_r;
    end
  end

  // Stage C: shift every magnitude so that the largest lies in [2^29, 2^30).
  lav_pkg::nrm_t         c_nxt;
  lav_pkg::nrm_t         c_r;
  logic                  c_v_r;
  logic [lav_pkg::NW-1:0] csh;

  always_comb begin
    c_nxt      = '0;
    c_nxt.zero = b_zero_r;
    c_nxt.neg  = b_neg_r;
    c_nxt.side = b_side_r;
    csh        = '0;
    for (int i = 0; i < 3; i++) begin
      if (b_pos_r >= 6'd30) begin
        csh = b_mag_r[i] >> (b_pos_r - 6'd29);
      end else begin
        csh = b_mag_r[i] << (6'd29 - b_pos_r);
      end
      c_nxt.m[i] = csh[lav_pkg::MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  // Stage D: squares of the aligned magnitudes.
  lav_pkg::nrm_t   d_r;
  logic            d_v_r;
  logic [2:0][59:0] d_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= c_r;
      for (int i = 0; i < 3; i++) begin
        d_sq_r[i] <= lav_pkg::mul_30x30(c_r.m[i], c_r.m[i]);
      end
    end
  end

  // Stage E: sum of squares opens the root pipeline.
  lav_pkg::nrm_t p_r  [0:NP-1];
  logic          pv_r [0:NP-1];
  lav_pkg::nrm_t e_nxt;

  always_comb begin
    e_nxt     = d_r;
    e_nxt.s   = {4'd0, d_sq_r[0]} + {4'd0, d_sq_r[1]} + {4'd0, d_sq_r[2]};
    e_nxt.res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r[0] <= 1'b0;
    end else if (en) begin
      pv_r[0] <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= e_nxt;
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    lav_pkg::nrm_t nx;
    logic [63:0]   trial;

    always_comb begin
      nx    = p_r[g];
      trial = p_r[g].res + BIT;
      if (p_r[g].s >= trial) begin
        nx.s   = p_r[g].s - trial;
        nx.res = (p_r[g].res >> 1) + BIT;
      end else begin
        nx.res = p_r[g].res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[g+1] <= 1'b0;
      end else if (en) begin
        pv_r[g+1] <= pv_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[g+1] <= nx;
      end
    end
  end

  // Rounded division of each magnitude by the length, one quotient bit per stage.
  for (genvar j = 0; j < NDV; j++) begin : g_div
    localparam int SH = NDV - 1 - j;
    lav_pkg::nrm_t        src;
    lav_pkg::nrm_t        nx;
    logic [lav_pkg::RW-1:0] dvs;

    if (j == 0) begin : g_prep
      always_comb begin
        src     = p_r[NSQ];
        src.len = p_r[NSQ].res[30:0];
        for (int i = 0; i < 3; i++) begin
          src.rem[i] = {2'd0, p_r[NSQ].m[i], 16'd0} + {18'd0, p_r[NSQ].res[30:1]};
        end
        src.q = '0;
      end
    end else begin : g_pass
      assign src = p_r[NSQ+j];
    end

    always_comb begin
      nx  = src;
      dvs = {17'd0, src.len} << SH;
      for (int i = 0; i < 3; i++) begin
        if (src.rem[i] >= dvs) begin
          nx.rem[i]   = src.rem[i] - dvs;
          nx.q[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[NSQ+j+1] <= 1'b0;
      end else if (en) begin
        pv_r[NSQ+j+1] <= pv_r[NSQ+j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[NSQ+j+1] <= nx;
      end
    end
  end

  // Final stage: clamp to one, apply the sign, force zero-length vectors to zero.
  logic [2:0][17:0] fn;
  logic [16:0]      fq;
  logic             out_v_r;
  logic [2:0][17:0] out_n_r;
  logic [lav_pkg::SDW-1:0] out_side_r;

  always_comb begin
    fq = '0;
    for (int i = 0; i < 3; i++) begin
      fq = p_r[NP-1].q[i];
      if (fq > lav_pkg::ONE_Q16) begin
        fq = lav_pkg::ONE_Q16;
      end
      if (p_r[NP-1].zero) begin
        fn[i] = '0;
      end else if (p_r[NP-1].neg[i]) begin
        fn[i] = ~{1'b0, fq} + 18'd1;
      end else begin
        fn[i] = {1'b0, fq};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= pv_r[NP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_n_r    <= fn;
      out_side_r <= p_r[NP-1].side;
    end
  end

  assign out_v    = out_v_r;
  assign out_n    = out_n_r;
  assign out_side = out_side_r;

endmodule
`default_nettype wire

[rtl/lav_tail.sv]
// Camera up axis and translation terms, ending in the output register.
`default_nettype none
module lav_tail (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [2:0][17:0] in_rt,
  input  logic [2:0][17:0] in_bk,
  input  logic [2:0][31:0] in_eye,
  output logic             out_v,
  output logic [2:0][17:0] out_rt,
  output logic [2:0][17:0] out_cu,
  output logic [2:0][17:0] out_bk,
  output logic [2:0][31:0] out_sh
);

  localparam int NT = 8;

  lav_pkg::tl_t t_r   [1:NT];
  logic         tv_r  [1:NT];
  lav_pkg::tl_t t_nxt [1:NT];

  // Stage 1: cross product terms of back and right, dot terms with the eye.
  always_comb begin
    t_nxt[1]     = '0;
    t_nxt[1].rt  = in_rt;
    t_nxt[1].bk  = in_bk;
    t_nxt[1].eye = in_eye;
    t_nxt[1].pa[0] = lav_pkg::mul_18x18(in_bk[1], in_rt[2]);
    t_nxt[1].pb[0] = lav_pkg::mul_18x18(in_bk[2], in_rt[1]);
    t_nxt[1].pa[1] = lav_pkg::mul_18x18(in_bk[2], in_rt[0]);
    t_nxt[1].pb[1] = lav_pkg::mul_18x18(in_bk[0], in_rt[2]);
    t_nxt[1].pa[2] = lav_pkg::mul_18x18(in_bk[0], in_rt[1]);
    t_nxt[1].pb[2] = lav_pkg::mul_18x18(in_bk[1], in_rt[0]);
    for (int i = 0; i < 3; i++) begin
      t_nxt[1].pr[i] = lav_pkg::mul_32x18(in_eye[i], in_rt[i]);
      t_nxt[1].pk[i] = lav_pkg::mul_32x18(in_eye[i], in_bk[i]);
    end
  end

  // Stage 2: cross differences and dot sums.
  always_comb begin
    t_nxt[2] = t_r[1];
    for (int i = 0; i < 3; i++) begin
      t_nxt[2].yd[i] = {t_r[1].pa[i][35], t_r[1].pa[i]} - {t_r[1].pb[i][35], t_r[1].pb[i]};
    end
    t_nxt[2].dr = {{2{t_r[1].pr[0][49]}}, t_r[1].pr[0]} + {{2{t_r[1].pr[1][49]}}, t_r[1].pr[1]}
                + {{2{t_r[1].pr[2][49]}}, t_r[1].pr[2]};
    t_nxt[2].db = {{2{t_r[1].pk[0][49]}}, t_r[1].pk[0]} + {{2{t_r[1].pk[1][49]}}, t_r[1].pk[1]}
                + {{2{t_r[1].pk[2][49]}}, t_r[1].pk[2]};
  end

  // Stage 3: sign and magnitude of the cross differences and the right and back dots.
  always_comb begin
    t_nxt[3] = t_r[2];
    for (int i = 0; i < 3; i++) begin
      t_nxt[3].yneg[i] = t_r[2].yd[i][36];
      t_nxt[3].ymag[i] = t_r[2].yd[i][36] ? (~t_r[2].yd[i] + 37'd1) : t_r[2].yd[i];
    end
    t_nxt[3].drn = t_r[2].dr[51];
    t_nxt[3].drm = t_r[2].dr[51] ? (~t_r[2].dr + 52'd1) : t_r[2].dr;
    t_nxt[3].dbn = t_r[2].db[51];
    t_nxt[3].dbm = t_r[2].db[51] ? (~t_r[2].db + 52'd1) : t_r[2].db;
  end

  // Stage 4: camera up axis and the right and back translations.
  always_comb begin
    t_nxt[4] = t_r[3];
    for (int i = 0; i < 3; i++) begin
      t_nxt[4].cu[i] = lav_pkg::unit_rnd(t_r[3].ymag[i], t_r[3].yneg[i]);
    end
    t_nxt[4].shx = lav_pkg::neg_sat(t_r[3].drm, t_r[3].drn);
    t_nxt[4].shz = lav_pkg::neg_sat(t_r[3].dbm, t_r[3].dbn);
  end

  // Stage 5: dot terms of the camera up axis with the eye.
  always_comb begin
    t_nxt[5] = t_r[4];
    for (int i = 0; i < 3; i++) begin
      t_nxt[5].pu[i] = lav_pkg::mul_32x18(t_r[4].eye[i], t_r[4].cu[i]);
    end
  end

  // Stage 6: sum of the up dot terms.
  always_comb begin
    t_nxt[6] = t_r[5];
    t_nxt[6].du = {{2{t_r[5].pu[0][49]}}, t_r[5].pu[0]} + {{2{t_r[5].pu[1][49]}}, t_r[5].pu[1]}
                + {{2{t_r[5].pu[2][49]}}, t_r[5].pu[2]};
  end

  // Stage 7: sign and magnitude of the up dot.
  always_comb begin
    t_nxt[7] = t_r[6];
    t_nxt[7].dun = t_r[6].du[51];
    t_nxt[7].dum = t_r[6].du[51] ? (~t_r[6].du + 52'd1) : t_r[6].du;
  end

  // Stage 8: up translation; this stage is the output register.
  always_comb begin
    t_nxt[8] = t_r[7];
    t_nxt[8].shy = lav_pkg::neg_sat(t_r[7].dum, t_r[7].dun);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NT; k++) begin
        tv_r[k] <= 1'b0;
      end
    end else if (en) begin
      tv_r[1] <= in_v;
      for (int k = 2; k <= NT; k++) begin
        tv_r[k] <= tv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= NT; k++) begin
        t_r[k] <= t_nxt[k];
      end
    end
  end

  assign out_v  = tv_r[NT];
  assign out_rt = t_r[NT].rt;
  assign out_cu = t_r[NT].cu;
  assign out_bk = t_r[NT].bk;
  assign out_sh = {t_r[NT].shz, t_r[NT].shy, t_r[NT].shx};

endmodule
`default_nettype wire

[rtl/look_at_view_matrix.sv]
// Top level of the pipelined right-handed look-at view matrix block.
//
//  Channel  Direction  Payload
//  in_      slave      eye, target and world-up vectors, nine Q16.16 words
//  out_     master     right, camera up and back axes, three translations
//
// One request enters per cycle while the output is not stalled; the two
// normalize units have 55 stages each (alignment, 32 root stages, 17 divide
// stages). Reset is synchronous, active low, and clears only the valid bits
// and the input skid. A stall on the output freezes the whole pipeline; the
// input skid still takes one more request, so in_tready is a registered
// signal.
`default_nettype none
module look_at_view_matrix (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z (32 bits each)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // right_x/y/z, cam_up_x/y/z, back_x/y/z (18 bits each), shift_x/y/z (32 bits each),
  // six zero bits
  output logic [263:0] out_tdata
);

  logic en;
  assign en = !out_tvalid || out_tready;

  // Input skid and first register.
  logic         skid_v_r;
  logic [287:0] skid_d_r;
  logic         s0_v_r;
  logic [287:0] s0_d_r;

  assign in_tready = !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      s0_v_r   <= 1'b0;
    end else if (en) begin
      s0_v_r   <= skid_v_r || in_tvalid;
      skid_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_d_r <= skid_v_r ? skid_d_r : in_tdata;
    end
    if (!en && !skid_v_r) begin
      skid_d_r <= in_tdata;
    end
  end

  // View direction eye - target.
  logic                           s1_v_r;
  logic [2:0][lav_pkg::NW-1:0]    s1_dz_r;
  logic [lav_pkg::SDW-1:0]        s1_side_r;
  logic [2:0][32:0]               dz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dz[i] = {s0_d_r[32*i+31], s0_d_r[32*i +: 32]}
            - {s0_d_r[32*(i+3)+31], s0_d_r[32*(i+3) +: 32]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_dz_r[i] <= {{17{dz[i][32]}}, dz[i]};
      end
      s1_side_r <= {s0_d_r[287:192], s0_d_r[95:0]};
    end
  end

  // Back axis.
  logic                    n1_v;
  logic [2:0][17:0]        n1_bk;
  logic [lav_pkg::SDW-1:0] n1_side;

  lav_norm u_norm_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s1_v_r),
    .in_c     (s1_dz_r),
    .in_side  (s1_side_r),
    .out_v    (n1_v),
    .out_n    (n1_bk),
    .out_side (n1_side)
  );

  // Cross product of world up and back, products then differences.
  logic             c1_v_r;
  logic [5:0][49:0] c1_p_r;
  logic [2:0][17:0] c1_bk_r;
  logic [95:0]      c1_eye_r;
  logic [2:0][31:0] up;

  assign up = n1_side[191:96];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_p_r[0] <= lav_pkg::mul_32x18(up[1], n1_bk[2]);
      c1_p_r[1] <= lav_pkg::mul_32x18(up[2], n1_bk[1]);
      c1_p_r[2] <= lav_pkg::mul_32x18(up[2], n1_bk[0]);
      c1_p_r[3] <= lav_pkg::mul_32x18(up[0], n1_bk[2]);
      c1_p_r[4] <= lav_pkg::mul_32x18(up[0], n1_bk[1]);
      c1_p_r[5] <= lav_pkg::mul_32x18(up[1], n1_bk[0]);
      c1_bk_r   <= n1_bk;
      c1_eye_r  <= n1_side[95:0];
    end
  end

  logic                        c2_v_r;
  logic [2:0][lav_pkg::NW-1:0] c2_x_r;
  logic [lav_pkg::SDW-1:0]     c2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_v_r <= 1'b0;
    end else if (en) begin
      c2_v_r <= c1_v_r;
    end
  end

  // The differences stay below 2^48 in magnitude and fit the normalize input.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c2_x_r[i] <= c1_p_r[2*i] - c1_p_r[2*i+1];
      end
      c2_side_r <= {42'd0, c1_bk_r, c1_eye_r};
    end
  end

  // Right axis.
  logic                    n2_v;
  logic [2:0][17:0]        n2_rt;
  logic [lav_pkg::SDW-1:0] n2_side;

  lav_norm u_norm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (c2_v_r),
    .in_c     (c2_x_r),
    .in_side  (c2_side_r),
    .out_v    (n2_v),
    .out_n    (n2_rt),
    .out_side (n2_side)
  );

  // Camera up axis, translations and output register.
  logic [2:0][17:0] o_rt;
  logic [2:0][17:0] o_cu;
  logic [2:0][17:0] o_bk;
  logic [2:0][31:0] o_sh;

  lav_tail u_tail (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (n2_v),
    .in_rt  (n2_rt),
    .in_bk  (n2_side[149:96]),
    .in_eye (n2_side[95:0]),
    .out_v  (out_tvalid),
    .out_rt (o_rt),
    .out_cu (o_cu),
    .out_bk (o_bk),
    .out_sh (o_sh)
  );

  assign out_tdata = {6'd0, o_sh, o_bk, o_cu, o_rt};

endmodule
`default_nettype wire

[rtl/lav_chk.sv]
// Port-level checker of the look-at view matrix block and its bind.
`default_nettype none
module lav_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [287:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [263:0] out_tdata
);

  logic unused_in;
  assign unused_in = in_tvalid ^ in_tdata[0];

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // The input only backs off after the output has stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  // The right axis x entry lies within one.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[17:0]) <= 18'sd65536 &&
                    $signed(out_tdata[17:0]) >= -18'sd65536))
    else $error("axis entry out of range");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (.*);
`default_nettype wire
